@@ rtl/core/rpn_pkg.sv @@
// Shared types and constants for the RPN character stream evaluator.
// Holds the value and status widths, character codes, operator and state enums.
// No dependencies.
package rpn_pkg;

    localparam int VAL_W           = 48;
    localparam int STAT_W          = 3;
    localparam int CHAR_W          = 8;
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_FRAC_BITS   = 16;

    localparam logic [STAT_W-1:0] ST_OK   = 3'd0;
    localparam logic [STAT_W-1:0] ST_FEW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_DIV0 = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD  = 3'd3;
    localparam logic [STAT_W-1:0] ST_MANY = 3'd4;
    localparam logic [STAT_W-1:0] ST_OVF  = 3'd5;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} t_op;

    typedef enum logic [1:0] {CL_SPACE, CL_DIGIT, CL_OPER, CL_BAD} t_cls;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_READ_L, S_LOAD, S_WAIT, S_FIN_RD, S_FIN_OUT
    } t_state;

    typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_DONE} t_alu_ph;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } t_alu_rsp;

endpackage

@@ rtl/core/rpn_alu.sv @@
// Shared iterative arithmetic unit: saturating add, subtract, shift-add
// multiply and restoring divide, all on one adder. Depends on rpn_pkg.
module rpn_alu import rpn_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alu_req         i_req,
    input  logic [VAL_W-1:0] i_lhs,
    input  logic [VAL_W-1:0] i_rhs,
    output t_alu_rsp         o_rsp
);

    localparam int DW    = VAL_W + FRAC_BITS;
    localparam int PW    = 2 * VAL_W;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(VAL_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DW - 1);
    localparam logic [VAL_W-1:0] MAX_V = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] MIN_V = {1'b1, {(VAL_W-1){1'b0}}};

    t_alu_ph          r_ph, n_ph;
    t_op              r_op;
    logic             r_neg;
    logic [VAL_W-1:0] r_x, r_y, r_hi;
    logic [DW-1:0]    r_lo;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [VAL_W-1:0] w_mag_l, w_mag_r;
    logic [VAL_W+1:0] w_ax, w_ay, w_sum;
    logic             w_cin;
    logic [VAL_W:0]   w_rem_sh;
    logic             w_nonneg;
    logic [PW-1:0]    w_prod, w_shift;
    logic             w_big;
    logic [VAL_W-2:0] w_mag;
    logic [VAL_W-1:0] w_res;
    logic [CNT_W-1:0] w_last;

    assign w_mag_l  = i_lhs[VAL_W-1] ? (~i_lhs + 1'b1) : i_lhs;
    assign w_mag_r  = i_rhs[VAL_W-1] ? (~i_rhs + 1'b1) : i_rhs;
    assign w_rem_sh = {r_hi, r_lo[DW-1]};
    assign w_last   = (r_op == OP_MUL) ? MUL_LAST : DIV_LAST;

    always_comb begin
        w_ax  = {{2{r_x[VAL_W-1]}}, r_x};
        w_ay  = {{2{r_y[VAL_W-1]}}, r_y};
        w_cin = 1'b0;
        unique case (r_op)
            OP_ADD: begin
            end
            OP_SUB: begin
                w_ay  = ~{{2{r_y[VAL_W-1]}}, r_y};
                w_cin = 1'b1;
            end
            OP_MUL: begin
                w_ax = {2'b00, r_hi};
                w_ay = r_lo[0] ? {2'b00, r_y} : '0;
            end
            OP_DIV: begin
                w_ax  = {1'b0, w_rem_sh};
                w_ay  = ~{2'b00, r_y};
                w_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_sum    = w_ax + w_ay + {{(VAL_W+1){1'b0}}, w_cin};
    assign w_nonneg = ~w_sum[VAL_W+1];

    assign w_prod  = {r_hi, r_lo[DW-1 -: VAL_W]};
    assign w_shift = w_prod >> FRAC_BITS;

    always_comb begin
        w_big = 1'b0;
        w_mag = '0;
        w_res = '0;
        unique case (r_op)
            OP_ADD, OP_SUB: begin
                if (w_sum[VAL_W+1] != w_sum[VAL_W] || w_sum[VAL_W] != w_sum[VAL_W-1]) begin
                    w_res = w_sum[VAL_W+1] ? MIN_V : MAX_V;
                end else begin
                    w_res = w_sum[VAL_W-1:0];
                end
            end
            OP_MUL, OP_DIV: begin
                if (r_op == OP_MUL) begin
                    w_big = |w_shift[PW-1:VAL_W-1];
                    w_mag = w_shift[VAL_W-2:0];
                end else begin
                    w_big = |r_lo[DW-1:VAL_W-1];
                    w_mag = r_lo[VAL_W-2:0];
                end
                if (w_big) begin
                    w_res = r_neg ? MIN_V : MAX_V;
                end else if (r_neg) begin
                    w_res = ~{1'b0, w_mag} + 1'b1;
                end else begin
                    w_res = {1'b0, w_mag};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ph  = r_ph;
        n_cnt = r_cnt;
        unique case (r_ph)
            PH_IDLE: begin
                if (i_req.start) begin
                    n_ph  = (i_req.op == OP_ADD || i_req.op == OP_SUB) ? PH_DONE : PH_RUN;
                    n_cnt = '0;
                end
            end
            PH_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == w_last) begin
                    n_ph = PH_DONE;
                end
            end
            PH_DONE: n_ph = PH_IDLE;
            default: n_ph = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_IDLE;
            r_cnt <= '0;
        end else begin
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph == PH_IDLE && i_req.start) begin
            r_op  <= i_req.op;
            r_neg <= i_lhs[VAL_W-1] ^ i_rhs[VAL_W-1];
            r_x   <= i_lhs;
            r_y   <= (i_req.op == OP_MUL || i_req.op == OP_DIV) ? w_mag_r : i_rhs;
            r_hi  <= '0;
            if (i_req.op == OP_DIV) begin
                r_lo <= DW'(w_mag_l) << FRAC_BITS;
            end else begin
                r_lo <= DW'(w_mag_l);
            end
        end else if (r_ph == PH_RUN) begin
            if (r_op == OP_MUL) begin
                r_hi <= w_sum[VAL_W:1];
                r_lo <= {w_sum[0], r_lo[DW-1:1]};
            end else begin
                r_hi <= w_nonneg ? w_sum[VAL_W-1:0] : w_rem_sh[VAL_W-1:0];
                r_lo <= {r_lo[DW-2:0], w_nonneg};
            end
        end
    end

    assign o_rsp.done  = (r_ph == PH_DONE);
    assign o_rsp.value = w_res;

endmodule

@@ rtl/core/rpn_char_stream_evaluator.sv @@
// Top level of the RPN character stream evaluator: decoder, sequencer,
// operand stack memory and output register. Depends on rpn_pkg and rpn_alu.
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+------------------------------------
// input   | in        | i_valid / o_ready  | i_character, i_end_of_expression
// output  | out       | o_valid / i_ready  | o_result_value, o_status
//
// Whitespace, digit or bad byte: S_IDLE, S_DECODE. Operators add S_READ_L, S_LOAD, S_WAIT;
// multiply and divide iterate bit-serially on the shared adder, add and subtract do not.
// End-marked item: S_FIN_RD for the stack read, then S_FIN_OUT, held while a result waits.
// Synchronous active-low reset empties the stack and clears the error.
// A result waiting in the output register stalls only the next end-marked item.
module rpn_char_stream_evaluator import rpn_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_end_of_expression,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [VAL_W-1:0]  o_result_value,
    output logic [STAT_W-1:0] o_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [STAT_W-1:0] r_err, n_err;
    logic [CHAR_W-1:0] r_char;
    logic              r_eoe;
    t_op               r_op;
    logic [VAL_W-1:0]  r_rhs;
    logic              r_o_valid;
    logic [VAL_W-1:0]  r_o_value;
    logic [STAT_W-1:0] r_o_status;

    logic [VAL_W-1:0]  r_stack [STACK_DEPTH];
    logic [VAL_W-1:0]  r_rd_data;

    t_cls              w_cls;
    t_op               w_op;
    logic [VAL_W-1:0]  w_digit;
    logic [CW-1:0]     w_cnt_m1, w_cnt_m2;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr, w_rd_addr;
    logic [VAL_W-1:0]  w_wr_data;
    logic              w_out_free, w_out_load;
    logic [STAT_W-1:0] w_fin_status;
    logic              w_div0;
    t_state            w_post;
    t_alu_req          w_req;
    t_alu_rsp          w_rsp;

    rpn_alu #(
        .FRAC_BITS(FRAC_BITS)
    ) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .i_lhs  (r_rd_data),
        .i_rhs  (r_rhs),
        .o_rsp  (w_rsp)
    );

    always_comb begin
        w_cls = CL_BAD;
        w_op  = OP_ADD;
        unique case (r_char) inside
            CH_SPACE, [CH_TAB:CH_CR]: w_cls = CL_SPACE;
            [CH_ZERO:CH_NINE]:        w_cls = CL_DIGIT;
            CH_PLUS: begin
                w_cls = CL_OPER;
                w_op  = OP_ADD;
            end
            CH_MINUS: begin
                w_cls = CL_OPER;
                w_op  = OP_SUB;
            end
            CH_STAR: begin
                w_cls = CL_OPER;
                w_op  = OP_MUL;
            end
            CH_SLASH: begin
                w_cls = CL_OPER;
                w_op  = OP_DIV;
            end
            default: w_cls = CL_BAD;
        endcase
    end

    assign w_digit      = VAL_W'(r_char - CH_ZERO) << FRAC_BITS;
    assign w_cnt_m1     = r_count - CW'(1);
    assign w_cnt_m2     = r_count - CW'(2);
    assign w_post       = r_eoe ? S_FIN_RD : S_IDLE;
    assign w_div0       = (r_op == OP_DIV) && (r_rhs == '0);
    assign w_out_free   = !r_o_valid || i_ready;
    assign w_fin_status = (r_err != ST_OK) ? r_err :
                          (r_count != CW'(1)) ? ST_MANY : ST_OK;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_err == ST_OK && w_cls == CL_OPER && r_count >= CW'(2)) begin
                    n_state = S_READ_L;
                end else begin
                    n_state = w_post;
                end
            end
            S_READ_L: n_state = S_LOAD;
            S_LOAD:   n_state = w_div0 ? w_post : S_WAIT;
            S_WAIT: begin
                if (w_rsp.done) begin
                    n_state = w_post;
                end
            end
            S_FIN_RD: n_state = S_FIN_OUT;
            S_FIN_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_err      = r_err;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_count[AW-1:0];
        w_wr_data  = w_digit;
        w_rd_addr  = '0;
        w_req      = '{start: 1'b0, op: r_op};
        w_out_load = 1'b0;
        unique case (r_state)
            S_DECODE: begin
                if (r_err == ST_OK) begin
                    unique case (w_cls)
                        CL_SPACE: begin
                        end
                        CL_DIGIT: begin
                            if (r_count >= CW'(STACK_DEPTH)) begin
                                n_err = ST_OVF;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CL_OPER: begin
                            if (r_count < CW'(2)) begin
                                n_err = ST_FEW;
                            end else begin
                                w_rd_addr = w_cnt_m1[AW-1:0];
                            end
                        end
                        CL_BAD: n_err = ST_BAD;
                        default: n_err = ST_BAD;
                    endcase
                end
            end
            S_READ_L: w_rd_addr = w_cnt_m2[AW-1:0];
            S_LOAD: begin
                w_rd_addr = w_cnt_m2[AW-1:0];
                if (w_div0) begin
                    n_err = ST_DIV0;
                end else begin
                    w_req.start = 1'b1;
                end
            end
            S_WAIT: begin
                w_rd_addr = w_cnt_m2[AW-1:0];
                if (w_rsp.done) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_cnt_m2[AW-1:0];
                    w_wr_data = w_rsp.value;
                    n_count   = w_cnt_m1;
                end
            end
            S_FIN_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_count    = '0;
                    n_err      = ST_OK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_stack[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_err     <= ST_OK;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_char <= i_character;
            r_eoe  <= i_end_of_expression;
        end
        if (r_state == S_DECODE) begin
            r_op <= w_op;
        end
        if (r_state == S_READ_L) begin
            r_rhs <= r_rd_data;
        end
        if (w_out_load) begin
            r_o_status <= w_fin_status;
            r_o_value  <= (w_fin_status == ST_OK) ? r_rd_data : '0;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_result_value = r_o_value;
    assign o_status       = r_o_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_err_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_result_value == '0))
        else $error("error result carries nonzero value");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after request accepted");

    a_alu_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WAIT))
        else $error("arithmetic unit finished outside wait state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("pending result dropped or changed");

endmodule
